// File: sv/xxh_pkg.sv
// xxh_pkg: shared types, constants and helpers for the XXH64 hash engine.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package xxh_pkg;

   localparam logic [63:0] P64_1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] P64_2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] P64_3 = 64'h165667B19E3779F9;
   localparam logic [63:0] P64_4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] P64_5 = 64'h27D4EB2F165667C5;

   localparam logic [3:0] WORD_BYTES = 4'd8;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_STG_P2,
      OP_LANE_P2,
      OP_ROT31_P1,
      OP_RND_B,
      OP_MRG_H,
      OP_T8_H,
      OP_T4_A,
      OP_T4_H,
      OP_T1_A,
      OP_T1_H,
      OP_AV1,
      OP_AV2,
      OP_HSUM,
      OP_HSMALL,
      OP_HLEN_FIN
   } op_type;

   // OP_HLEN_FIN adds the length; the final load is marked by fin alone
   typedef struct packed {
      op_type     op;
      logic       fin;
      logic       take;
      logic [1:0] idx;
      logic [4:0] pos;
   } cmd_type;

   typedef struct packed {
      logic       mul_done;
      logic       wrap;
      logic       ge32;
      logic       rsp_full;
      logic [5:0] tail;
   } stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RND_A,
      ST_RND_B,
      ST_DIG,
      ST_MRG_A,
      ST_MRG_B,
      ST_MRG_H,
      ST_HLEN,
      ST_TAIL,
      ST_T8_A,
      ST_T8_B,
      ST_T8_H,
      ST_T4_A,
      ST_T4_H,
      ST_T1_A,
      ST_T1_H,
      ST_AV1,
      ST_AV2,
      ST_FIN
   } state_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
   endfunction

endpackage

`default_nettype wire

// File: sv/xxh_if.sv
// Valid/ready channel interfaces for the XXH64 hash engine.
// Depends on nothing; request, response and seed-write channels.
`default_nettype none

interface xxh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  byte_count;
   logic        last;
   modport source (output valid, data_word, byte_count, last, input ready);
   modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface xxh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

interface xxh_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] seed;
   modport source (output valid, seed, input ready);
   modport sink (input valid, seed, output ready);
endinterface

`default_nettype wire

// File: sv/xxh_mul.sv
// xxh_mul: 64x64 low-half multiplier built from one 32x32 multiplier.
// No package dependency.
`default_nettype none

module xxh_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        run,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      result
);

   logic [1:0]  ph_ff, ph_in;
   logic [63:0] pr_ff, pr_in;
   logic [63:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] ma, mb;

   // phase 0: lo*lo, phase 1: hi*lo, phase 2: lo*hi, phase 3: result ready
   always_comb begin
      case (ph_ff)
         2'd1: begin
            ma = a[63:32];
            mb = b[31:0];
         end
         2'd2: begin
            ma = a[31:0];
            mb = b[63:32];
         end
         default: begin
            ma = a[31:0];
            mb = b[31:0];
         end
      endcase
      pr_in = 64'(ma) * 64'(mb);
      ph_in = run ? ph_ff + 2'd1 : 2'd0;
      lo_in = (ph_ff == 2'd1) ? pr_ff : lo_ff;
      hi_in = (ph_ff == 2'd2) ? pr_ff[31:0] + lo_ff[63:32] : hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 2'd0;
      end else begin
         ph_ff <= ph_in;
      end
      pr_ff <= pr_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign done   = run && (ph_ff == 2'd3);
   assign result = {hi_ff + pr_ff[31:0], lo_ff[31:0]};

endmodule

`default_nettype wire

// File: sv/xxh_dp.sv
// xxh_dp: lanes, stripe staging, length, digest accumulator and output register.
// Depends on xxh_pkg and xxh_mul.
`default_nettype none

module xxh_dp #(
   parameter int LENGTH_BITS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire xxh_pkg::cmd_type  cmd,
   output xxh_pkg::stat_type      stat,
   input  wire logic [63:0]       data_word,
   input  wire logic [3:0]        byte_count,
   input  wire logic              last,
   input  wire logic              csr_write,
   input  wire logic [63:0]       csr_seed,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [63:0]            rsp_hash
);

   typedef enum logic [1:0] {DST_NONE, DST_T, DST_H, DST_LANE} dest_type;

   localparam logic [3:0] WORD_BYTES_L = xxh_pkg::WORD_BYTES;

   logic [63:0]            lane_ff [4];
   logic [63:0]            lane_in [4];
   logic [63:0]            stage_ff [4];
   logic [1:0]             cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic [63:0]            seed_ff, seed_in;
   logic [63:0]            h_ff, h_in;
   logic [63:0]            t_ff, t_in;
   logic                   rv_ff, rv_in;
   logic [63:0]            rh_ff, rh_in;

   logic [3:0]  n_sat;
   logic        full_word;
   logic [1:0]  cnt_inc;
   logic [63:0] masked;
   logic        stage_wr;
   logic [63:0] stage_wdata;
   logic [63:0] stg_sel, lane_sel;
   logic [7:0]  byte_sel;
   logic [63:0] ht;
   logic        mul_run;
   logic [63:0] mul_a, mul_b, add_c;
   dest_type    dest;
   logic        mul_done;
   logic [63:0] mul_res, mul_out;

   assign n_sat     = (byte_count > WORD_BYTES_L) ? WORD_BYTES_L : byte_count;
   assign full_word = !last || (n_sat == WORD_BYTES_L);
   assign cnt_inc   = cnt_ff + 2'd1;
   assign stg_sel   = stage_ff[cmd.idx];
   assign lane_sel  = lane_ff[cmd.idx];
   assign byte_sel  = 8'(stage_ff[cmd.pos[4:3]] >> {cmd.pos[2:0], 3'b000});
   assign ht        = h_ff ^ t_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (3'(i) < n_sat[2:0]) ? data_word[i*8 +: 8] : 8'h00;
      end
   end

   // operand and destination selection for the shared multiplier
   always_comb begin
      mul_run = 1'b1;
      mul_a   = 64'd0;
      mul_b   = xxh_pkg::P64_1;
      add_c   = 64'd0;
      dest    = DST_T;
      case (cmd.op)
         xxh_pkg::OP_STG_P2: begin
            mul_a = stg_sel;
            mul_b = xxh_pkg::P64_2;
         end
         xxh_pkg::OP_LANE_P2: begin
            mul_a = lane_sel;
            mul_b = xxh_pkg::P64_2;
         end
         xxh_pkg::OP_ROT31_P1: begin
            mul_a = xxh_pkg::rotl(t_ff, 31);
         end
         xxh_pkg::OP_RND_B: begin
            mul_a = xxh_pkg::rotl(lane_sel + t_ff, 31);
            dest  = DST_LANE;
         end
         xxh_pkg::OP_MRG_H: begin
            mul_a = ht;
            add_c = xxh_pkg::P64_4;
            dest  = DST_H;
         end
         xxh_pkg::OP_T8_H: begin
            mul_a = xxh_pkg::rotl(ht, 27);
            add_c = xxh_pkg::P64_4;
            dest  = DST_H;
         end
         xxh_pkg::OP_T4_A: begin
            mul_a = {32'd0, stg_sel[31:0]};
         end
         xxh_pkg::OP_T4_H: begin
            mul_a = xxh_pkg::rotl(ht, 23);
            mul_b = xxh_pkg::P64_2;
            add_c = xxh_pkg::P64_3;
            dest  = DST_H;
         end
         xxh_pkg::OP_T1_A: begin
            mul_a = {56'd0, byte_sel};
            mul_b = xxh_pkg::P64_5;
         end
         xxh_pkg::OP_T1_H: begin
            mul_a = xxh_pkg::rotl(ht, 11);
            dest  = DST_H;
         end
         xxh_pkg::OP_AV1: begin
            mul_a = h_ff ^ (h_ff >> 33);
            mul_b = xxh_pkg::P64_2;
            dest  = DST_H;
         end
         xxh_pkg::OP_AV2: begin
            mul_a = h_ff ^ (h_ff >> 29);
            mul_b = xxh_pkg::P64_3;
            dest  = DST_H;
         end
         default: begin
            mul_run = 1'b0;
            dest    = DST_NONE;
         end
      endcase
   end

   xxh_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .run    (mul_run),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   assign mul_out = mul_res + add_c;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lane_in[k] = lane_ff[k];
      end
      cnt_in      = cnt_ff;
      total_in    = total_ff;
      seed_in     = seed_ff;
      h_in        = h_ff;
      t_in        = t_ff;
      rv_in       = rv_ff && !rsp_ready;
      rh_in       = rh_ff;
      stage_wr    = 1'b0;
      stage_wdata = masked;

      if (cmd.take) begin
         stage_wr = 1'b1;
         if (full_word) begin
            stage_wdata = data_word;
            cnt_in      = cnt_inc;
            total_in    = total_ff + LENGTH_BITS'(WORD_BYTES_L);
         end else begin
            total_in = total_ff + LENGTH_BITS'(n_sat);
         end
      end

      if (mul_done) begin
         case (dest)
            DST_T:    t_in = mul_out;
            DST_H:    h_in = mul_out;
            DST_LANE: lane_in[cmd.idx] = mul_out;
            default:  ;
         endcase
      end

      case (cmd.op)
         xxh_pkg::OP_HSUM: begin
            h_in = xxh_pkg::rotl(lane_ff[0], 1) + xxh_pkg::rotl(lane_ff[1], 7)
                 + xxh_pkg::rotl(lane_ff[2], 12) + xxh_pkg::rotl(lane_ff[3], 18);
         end
         xxh_pkg::OP_HSMALL: begin
            h_in = lane_ff[2] + xxh_pkg::P64_5;
         end
         xxh_pkg::OP_HLEN_FIN: begin
            if (!cmd.fin) begin
               h_in = h_ff + 64'(total_ff);
            end
         end
         default: ;
      endcase

      // the digest leaves, lanes restart for the next message
      if (cmd.fin) begin
         rv_in    = 1'b1;
         rh_in    = h_ff ^ (h_ff >> 32);
         cnt_in   = 2'd0;
         total_in = '0;
      end

      if (csr_write) begin
         seed_in = csr_seed;
      end

      if (cmd.fin || (csr_write && cnt_ff == 2'd0 && total_ff == '0)) begin
         lane_in[0] = seed_in + xxh_pkg::P64_1 + xxh_pkg::P64_2;
         lane_in[1] = seed_in + xxh_pkg::P64_2;
         lane_in[2] = seed_in;
         lane_in[3] = seed_in - xxh_pkg::P64_1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff[0] <= xxh_pkg::P64_1 + xxh_pkg::P64_2;
         lane_ff[1] <= xxh_pkg::P64_2;
         lane_ff[2] <= 64'd0;
         lane_ff[3] <= 64'd0 - xxh_pkg::P64_1;
         cnt_ff     <= 2'd0;
         total_ff   <= '0;
         seed_ff    <= 64'd0;
         rv_ff      <= 1'b0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            lane_ff[k] <= lane_in[k];
         end
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         seed_ff  <= seed_in;
         rv_ff    <= rv_in;
      end
      h_ff  <= h_in;
      t_ff  <= t_in;
      rh_ff <= rh_in;
      if (stage_wr) begin
         stage_ff[cnt_ff] <= stage_wdata;
      end
   end

   always_comb begin
      stat.mul_done = mul_done;
      stat.wrap     = full_word && (cnt_ff == 2'd3);
      stat.ge32     = (total_ff >= LENGTH_BITS'(32));
      stat.rsp_full = rv_ff;
      stat.tail     = full_word ? {1'b0, cnt_inc, 3'b000} : {1'b0, cnt_ff, n_sat[2:0]};
   end

   assign rsp_valid = rv_ff;
   assign rsp_hash  = rh_ff;

endmodule

`default_nettype wire

// File: sv/xxh_ctrl.sv
// xxh_ctrl: sequencer for stripe rounds, lane merge, tail steps and avalanche.
// Depends on xxh_pkg.
`default_nettype none

module xxh_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last,
   output logic                   req_ready,
   input  wire xxh_pkg::stat_type stat,
   output xxh_pkg::cmd_type       cmd
);

   xxh_pkg::state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic [5:0] pos_ff, pos_in;
   logic [5:0] tail_ff, tail_in;
   logic       dig_ff, dig_in;
   logic [5:0] rem;
   logic       take;

   assign take = (state_ff == xxh_pkg::ST_IDLE) && req_valid;
   assign rem  = tail_ff - pos_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      tail_in  = tail_ff;
      dig_in   = dig_ff;
      case (state_ff)
         xxh_pkg::ST_IDLE: begin
            if (take) begin
               tail_in = stat.tail;
               dig_in  = req_last;
               idx_in  = 2'd0;
               if (stat.wrap) begin
                  state_in = xxh_pkg::ST_RND_A;
               end else if (req_last) begin
                  state_in = xxh_pkg::ST_DIG;
               end
            end
         end
         xxh_pkg::ST_RND_A: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_RND_B;
         end
         xxh_pkg::ST_RND_B: begin
            if (stat.mul_done) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff != 2'd3) begin
                  state_in = xxh_pkg::ST_RND_A;
               end else if (dig_ff) begin
                  state_in = xxh_pkg::ST_DIG;
               end else begin
                  state_in = xxh_pkg::ST_IDLE;
               end
            end
         end
         xxh_pkg::ST_DIG: begin
            idx_in   = 2'd0;
            state_in = stat.ge32 ? xxh_pkg::ST_MRG_A : xxh_pkg::ST_HLEN;
         end
         xxh_pkg::ST_MRG_A: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_MRG_B;
         end
         xxh_pkg::ST_MRG_B: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_MRG_H;
         end
         xxh_pkg::ST_MRG_H: begin
            if (stat.mul_done) begin
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd3) ? xxh_pkg::ST_HLEN : xxh_pkg::ST_MRG_A;
            end
         end
         xxh_pkg::ST_HLEN: begin
            pos_in   = 6'd0;
            state_in = xxh_pkg::ST_TAIL;
         end
         xxh_pkg::ST_TAIL: begin
            if (rem >= 6'd8) begin
               state_in = xxh_pkg::ST_T8_A;
            end else if (rem >= 6'd4) begin
               state_in = xxh_pkg::ST_T4_A;
            end else if (rem != 6'd0) begin
               state_in = xxh_pkg::ST_T1_A;
            end else begin
               state_in = xxh_pkg::ST_AV1;
            end
         end
         xxh_pkg::ST_T8_A: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_T8_B;
         end
         xxh_pkg::ST_T8_B: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_T8_H;
         end
         xxh_pkg::ST_T8_H: begin
            if (stat.mul_done) begin
               pos_in   = pos_ff + 6'd8;
               state_in = xxh_pkg::ST_TAIL;
            end
         end
         xxh_pkg::ST_T4_A: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_T4_H;
         end
         xxh_pkg::ST_T4_H: begin
            if (stat.mul_done) begin
               pos_in   = pos_ff + 6'd4;
               state_in = xxh_pkg::ST_TAIL;
            end
         end
         xxh_pkg::ST_T1_A: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_T1_H;
         end
         xxh_pkg::ST_T1_H: begin
            if (stat.mul_done) begin
               pos_in   = pos_ff + 6'd1;
               state_in = xxh_pkg::ST_TAIL;
            end
         end
         xxh_pkg::ST_AV1: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_AV2;
         end
         xxh_pkg::ST_AV2: begin
            if (stat.mul_done) state_in = xxh_pkg::ST_FIN;
         end
         xxh_pkg::ST_FIN: begin
            if (!stat.rsp_full) begin
               dig_in   = 1'b0;
               state_in = xxh_pkg::ST_IDLE;
            end
         end
         default: state_in = xxh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op   = xxh_pkg::OP_NOP;
      cmd.fin  = 1'b0;
      cmd.take = take;
      cmd.idx  = idx_ff;
      cmd.pos  = pos_ff[4:0];
      req_ready = (state_ff == xxh_pkg::ST_IDLE);
      case (state_ff)
         xxh_pkg::ST_RND_A: cmd.op = xxh_pkg::OP_STG_P2;
         xxh_pkg::ST_RND_B: cmd.op = xxh_pkg::OP_RND_B;
         xxh_pkg::ST_DIG:   cmd.op = stat.ge32 ? xxh_pkg::OP_HSUM : xxh_pkg::OP_HSMALL;
         xxh_pkg::ST_MRG_A: cmd.op = xxh_pkg::OP_LANE_P2;
         xxh_pkg::ST_MRG_B: cmd.op = xxh_pkg::OP_ROT31_P1;
         xxh_pkg::ST_MRG_H: cmd.op = xxh_pkg::OP_MRG_H;
         xxh_pkg::ST_HLEN:  cmd.op = xxh_pkg::OP_HLEN_FIN;
         xxh_pkg::ST_T8_A: begin
            cmd.op  = xxh_pkg::OP_STG_P2;
            cmd.idx = pos_ff[4:3];
         end
         xxh_pkg::ST_T8_B:  cmd.op = xxh_pkg::OP_ROT31_P1;
         xxh_pkg::ST_T8_H:  cmd.op = xxh_pkg::OP_T8_H;
         xxh_pkg::ST_T4_A: begin
            cmd.op  = xxh_pkg::OP_T4_A;
            cmd.idx = pos_ff[4:3];
         end
         xxh_pkg::ST_T4_H:  cmd.op = xxh_pkg::OP_T4_H;
         xxh_pkg::ST_T1_A:  cmd.op = xxh_pkg::OP_T1_A;
         xxh_pkg::ST_T1_H:  cmd.op = xxh_pkg::OP_T1_H;
         xxh_pkg::ST_AV1:   cmd.op = xxh_pkg::OP_AV1;
         xxh_pkg::ST_AV2:   cmd.op = xxh_pkg::OP_AV2;
         xxh_pkg::ST_FIN: begin
            // hash held while the previous result waits
            cmd.fin = !stat.rsp_full;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xxh_pkg::ST_IDLE;
         dig_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         dig_ff   <= dig_in;
      end
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

// File: sv/xxh64_streaming_hash_top.sv
// XXH64 streaming hash engine, top level.
// Channels: req carries one 64-bit little-endian message word per handshake
// (data_word, byte_count, last); rsp returns hash_value once per message;
// csr writes the 64-bit seed. All channels are valid/ready.
// A word that neither fills a 32-byte stripe nor is last is only staged and
// req stays ready. A word that fills a stripe starts eight products on the
// shared multiplier (two per lane). A last word starts the digest: lane sum
//   or small-input start, a merge of each lane if length >= 32, length add,
//   8-byte, 4-byte and single-byte tail steps, avalanche and output load,
//   all paced by that one multiplier; req is not ready while either runs.
// The result sits in an output register; the next message may be taken
// while it waits, and a digest only stalls at its final load if rsp is
// still held off.
// Reset is synchronous: seed 0, lanes at their seed-0 start values, empty
// stripe and length. A seed write before any word of a message reloads the
// lanes at once, otherwise it applies from the next message.
`default_nettype none

module xxh64_streaming_hash_top #(
   parameter int LENGTH_BITS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   xxh_req_if.sink   req,
   xxh_rsp_if.source rsp,
   xxh_csr_if.sink   csr
);

   xxh_pkg::cmd_type  cmd;
   xxh_pkg::stat_type stat;

   assign csr.ready = 1'b1;

   xxh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   xxh_dp #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .data_word  (req.data_word),
      .byte_count (req.byte_count),
      .last       (req.last),
      .csr_write  (csr.valid),
      .csr_seed   (csr.seed),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_hash   (rsp.hash_value)
   );

   // a last word always starts work, so the next cycle cannot take a word
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last) |=> !req.ready)
      else $error("word taken right after a last word");

   // a result appears only from the final load of a digest
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.fin))
      else $error("result without a digest");

   // the final load never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> !rsp.valid)
      else $error("result overwritten");

endmodule

`default_nettype wire
